@@ src/lfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// shared constants and types of the lfu cache with lru tie-break
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int STAMP_W     = 48;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_W-1:0]    stamp;
  } lfu_entry_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      idx;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_W-1:0]    stamp;
  } lfu_wr_t;

  typedef struct packed {
    logic                  found_v;
    logic [IDX_W-1:0]      found_idx;
    logic [VAL_W-1:0]      found_value;
    logic [COUNT_BITS-1:0] found_count;
    logic                  free_v;
    logic [IDX_W-1:0]      free_idx;
    logic                  victim_v;
    logic [IDX_W-1:0]      victim_idx;
    logic [COUNT_BITS-1:0] victim_count;
    logic [STAMP_W-1:0]    victim_stamp;
    logic [USED_W-1:0]     used;
  } lfu_scan_t;

endpackage

@@ src/lfu_slot_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_slot_store
// slot storage: valid flags, keys, values, use counts and touch stamps
// ----------------------------------------------------------------------------
module lfu_slot_store import lfu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_idx_i,
  output lfu_entry_t       rd_entry_o,
  input  lfu_wr_t          wr_i
);

  logic [MAX_ENTRIES-1:0]  valid_q;
  logic [KEY_W-1:0]        key_q   [MAX_ENTRIES];
  logic [VAL_W-1:0]        value_q [MAX_ENTRIES];
  logic [COUNT_BITS-1:0]   count_q [MAX_ENTRIES];
  logic [STAMP_W-1:0]      stamp_q [MAX_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_q[wr_i.idx]   <= wr_i.key;
      value_q[wr_i.idx] <= wr_i.value;
      count_q[wr_i.idx] <= wr_i.count;
      stamp_q[wr_i.idx] <= wr_i.stamp;
    end
  end

  always_comb begin
    rd_entry_o.valid = valid_q[rd_idx_i];
    rd_entry_o.key   = key_q[rd_idx_i];
    rd_entry_o.value = value_q[rd_idx_i];
    rd_entry_o.count = count_q[rd_idx_i];
    rd_entry_o.stamp = stamp_q[rd_idx_i];
  end

endmodule

@@ src/lfu_scan_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_scan_unit
// shared compare unit: one slot per stepped cycle for key match, free slot and victim
// ----------------------------------------------------------------------------
module lfu_scan_unit import lfu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             step_i,
  input  logic [IDX_W-1:0] idx_i,
  input  lfu_entry_t       entry_i,
  input  logic [KEY_W-1:0] key_i,
  output lfu_scan_t        scan_o
);

  lfu_scan_t scan_q, scan_d;
  logic      key_match;
  logic      less_used;

  always_comb begin
    key_match = entry_i.valid && (entry_i.key == key_i);
    less_used = !scan_q.victim_v
             || (entry_i.count < scan_q.victim_count)
             || ((entry_i.count == scan_q.victim_count)
                 && (entry_i.stamp < scan_q.victim_stamp));
    scan_d = scan_q;
    if (clear_i) begin
      scan_d = '0;
    end else if (step_i) begin
      if (entry_i.valid) begin
        scan_d.used = scan_q.used + USED_W'(1);
        if (key_match && !scan_q.found_v) begin
          scan_d.found_v     = 1'b1;
          scan_d.found_idx   = idx_i;
          scan_d.found_value = entry_i.value;
          scan_d.found_count = entry_i.count;
        end
        if (less_used) begin
          scan_d.victim_v     = 1'b1;
          scan_d.victim_idx   = idx_i;
          scan_d.victim_count = entry_i.count;
          scan_d.victim_stamp = entry_i.stamp;
        end
      end else if (!scan_q.free_v) begin
        scan_d.free_v   = 1'b1;
        scan_d.free_idx = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

@@ src/lfu_cache_lru_tiebreak_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_core
// key-value cache, least-frequently-used replacement, oldest entry on ties
// ----------------------------------------------------------------------------
// usage
//   a request (op_i, lookup_key_i, store_value_i) transfers at a rising edge
//   with start high and busy low. busy then stays high through the scan
//   state, which steps the shared compare unit over every slot in turn,
//   and the update state, which writes the chosen slot. the result (hit_o,
//   read_value_o, evicted_o) shows for exactly one cycle with result_valid_o,
//   registered from the update state; busy is already low then, so a new
//   request may transfer in that same cycle. the scan always covers all
//   slots, whatever the capacity. the receiver cannot stall; results are
//   never held back. capacity is written over cfg_valid_i / cfg_data_i,
//   always ready; the user writes it only while no request is in flight,
//   which the block itself does not enforce.
//   reset empties every slot, clears the touch clock and sets capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_core import lfu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             op_i,
  input  logic [KEY_W-1:0] lookup_key_i,
  input  logic [VAL_W-1:0] store_value_i,
  output logic             result_valid_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] read_value_o,
  output logic             evicted_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 op_q;
  logic [KEY_W-1:0]     key_q;
  logic [VAL_W-1:0]     val_q;
  logic [CAP_W-1:0]     capacity_q;
  logic [STAMP_W-1:0]   touch_clock_q;
  logic                 result_valid_q;
  logic                 hit_q;
  logic [VAL_W-1:0]     read_value_q;
  logic                 evicted_q;

  logic                 accept;
  logic                 full;
  logic                 evict_d;
  logic [VAL_W-1:0]     read_value_d;
  logic [COUNT_BITS-1:0] bumped_count;
  lfu_entry_t           entry;
  lfu_wr_t              wr;
  lfu_scan_t            scan;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  lfu_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (entry),
    .wr_i       (wr)
  );

  lfu_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept),
    .step_i  (state_q == ST_SCAN),
    .idx_i   (idx_q),
    .entry_i (entry),
    .key_i   (key_q),
    .scan_o  (scan)
  );

  always_comb begin
    full = (32'(scan.used) >= 32'(capacity_q)) || !scan.free_v;
    bumped_count = (scan.found_count == COUNT_MAX) ? scan.found_count
                                                   : scan.found_count + COUNT_ONE;
    wr       = '0;
    wr.key   = key_q;
    wr.value = val_q;
    wr.stamp = touch_clock_q;
    wr.count = COUNT_ONE;
    wr.idx   = scan.free_idx;
    evict_d  = 1'b0;
    if (state_q == ST_UPDATE) begin
      if (scan.found_v && ((op_q == OP_GET) || (capacity_q != '0))) begin
        wr.en    = 1'b1;
        wr.idx   = scan.found_idx;
        wr.count = bumped_count;
        if (op_q == OP_GET) begin
          wr.value = scan.found_value;
        end
      end else if ((op_q == OP_PUT) && (capacity_q != '0) && !scan.found_v) begin
        if (!full) begin
          wr.en = 1'b1;
        end else if (scan.victim_v) begin
          wr.en   = 1'b1;
          wr.idx  = scan.victim_idx;
          evict_d = 1'b1;
        end
      end
    end
    if (op_q == OP_GET) begin
      read_value_d = scan.found_v ? scan.found_value : '1;
    end else begin
      read_value_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      idx_q          <= '0;
      op_q           <= OP_GET;
      key_q          <= '0;
      val_q          <= '0;
      capacity_q     <= CAP_RESET;
      touch_clock_q  <= '0;
      result_valid_q <= 1'b0;
      hit_q          <= 1'b0;
      read_value_q   <= '0;
      evicted_q      <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      if (wr.en) begin
        touch_clock_q <= touch_clock_q + STAMP_W'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= op_i;
            key_q   <= lookup_key_i;
            val_q   <= store_value_i;
            idx_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_q <= idx_q + IDX_W'(1);
          if (idx_q == IDX_W'(MAX_ENTRIES - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          result_valid_q <= 1'b1;
          hit_q          <= scan.found_v;
          read_value_q   <= read_value_d;
          evicted_q      <= evict_d;
          idx_q          <= '0;
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign hit_o          = hit_q;
  assign read_value_o   = read_value_q;
  assign evicted_o      = evicted_q;

  // result appears only after the update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_UPDATE))
    else $error("result without update cycle");

  // an eviction never reports a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_o) |-> !hit_o)
    else $error("eviction on a hit");

  // a transfer starts the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("scan not started");

  // touch clock steps by one per slot write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> (touch_clock_q == $past(touch_clock_q) + STAMP_W'(1)))
    else $error("touch clock step wrong");

endmodule
